// File: design/crc15_pec_framer_assert.svh
// Assertion macros shared by the framer's checking code.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef CRC15_PEC_FRAMER_ASSERT_SVH
`define CRC15_PEC_FRAMER_ASSERT_SVH

// Same-cycle implication, held off while reset is high.
`define PEC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("framer assertion failed");

// Next-cycle implication, held off while reset is high.
`define PEC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("framer assertion failed");

`endif

// File: design/crcpec_pkg.sv
package crcpec_pkg;

  // Longest group of data bytes covered by one code.
  localparam logic [3:0] MAX_GROUP = 4'd8;
  // CRC register value at the start of every group.
  localparam logic [14:0] PEC_SEED = 15'd16;
  // Generator polynomial, bit 14 being the feedback tap.
  localparam logic [15:0] PEC_POLY = 16'h4599;

  // Kinds of byte on the output channel.
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_CODE_HI = 2'd1;
  localparam logic [1:0] KIND_CODE_LO = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_CHECK_MODE  = 1'b0;
  localparam logic CFG_GROUP_BYTES = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] byte_kind;
    logic       group_done;
    logic       code_error;
    logic       last_of_run;
  } out_item_t;

  // Everything one accepted byte leaves for the output stage.
  typedef struct packed {
    out_item_t  head;
    logic       with_code;
    logic [15:0] code;
  } run_t;

  // One entry of the byte-wise CRC table: eight shifts of the index through
  // the polynomial. Only the low fifteen bits are ever used.
  function automatic logic [14:0] crc_entry(input logic [7:0] idx);
    logic [15:0] r;
    r = {1'b0, idx, 7'b0};
    for (int b = 0; b < 8; b++) begin
      if (r[14]) begin
        r = {r[14:0], 1'b0} ^ PEC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r[14:0];
  endfunction

endpackage

// File: design/crcpec_core.sv
module crcpec_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  crcpec_pkg::in_item_t item,
  input  logic                check_mode,
  input  logic [3:0]          group_bytes,
  output crcpec_pkg::run_t    run
);
  import crcpec_pkg::*;

  logic [14:0] crc_reg;
  logic [14:0] crc_reg_next;
  logic [3:0]  byte_count;
  logic [3:0]  byte_count_next;
  logic [7:0]  received_high;
  logic [7:0]  received_high_next;

  logic [3:0]  grp;
  logic [14:0] eff_crc;
  logic [3:0]  eff_cnt;
  logic [3:0]  cnt_inc;
  logic [14:0] fed_crc;
  logic [7:0]  b;

  // Clamp the group length and apply a frame restart ahead of this byte.
  always_comb begin
    b = item.data_byte;
    if (group_bytes == 4'd0) begin
      grp = 4'd1;
    end else if (group_bytes > MAX_GROUP) begin
      grp = MAX_GROUP;
    end else begin
      grp = group_bytes;
    end
    eff_crc = item.frame_start ? PEC_SEED : crc_reg;
    eff_cnt = item.frame_start ? 4'd0 : byte_count;
    cnt_inc = eff_cnt + 4'd1;
    fed_crc = {eff_crc[6:0], 8'b0} ^ crc_entry(eff_crc[14:7] ^ b);
  end

  // Decide what this byte produces and where the state goes.
  always_comb begin
    crc_reg_next       = eff_crc;
    byte_count_next    = eff_cnt;
    received_high_next = received_high;
    run.head.out_byte    = b;
    run.head.byte_kind   = KIND_DATA;
    run.head.group_done  = 1'b0;
    run.head.code_error  = 1'b0;
    run.head.last_of_run = 1'b1;
    run.with_code        = 1'b0;
    run.code             = {fed_crc, 1'b0};
    if (!check_mode) begin
      crc_reg_next    = fed_crc;
      byte_count_next = cnt_inc;
      if (cnt_inc >= grp) begin
        run.with_code        = 1'b1;
        run.head.last_of_run = 1'b0;
        crc_reg_next         = PEC_SEED;
        byte_count_next      = 4'd0;
      end
    end else if (eff_cnt < grp) begin
      crc_reg_next    = fed_crc;
      byte_count_next = cnt_inc;
    end else if (eff_cnt == grp) begin
      received_high_next = b;
      byte_count_next    = cnt_inc;
      run.head.byte_kind = KIND_CODE_HI;
    end else begin
      run.head.byte_kind  = KIND_CODE_LO;
      run.head.group_done = 1'b1;
      run.head.code_error = ({received_high, b} != {eff_crc, 1'b0});
      crc_reg_next        = PEC_SEED;
      byte_count_next     = 4'd0;
    end
  end

  // Running CRC, group count and the held high code byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg       <= PEC_SEED;
      byte_count    <= 4'd0;
      received_high <= 8'd0;
    end else if (accept) begin
      crc_reg       <= crc_reg_next;
      byte_count    <= byte_count_next;
      received_high <= received_high_next;
    end
  end

endmodule

// File: design/crcpec_out.sv
module crcpec_out (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  crcpec_pkg::run_t     run_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output crcpec_pkg::out_item_t out_data
);
  import crcpec_pkg::*;

  typedef enum logic [1:0] {PH_DATA, PH_HI, PH_LO} phase_t;

  phase_t phase;
  logic   valid;
  run_t   run;
  logic   is_last;
  logic   load;

  // The current transaction is the last of its run once the code bytes,
  // if any, have gone out.
  always_comb begin
    is_last  = (phase == PH_LO) || (phase == PH_DATA && !run.with_code);
    in_ready = !valid || (out_ready && is_last);
    load     = in_valid && in_ready;
    out_valid = valid;
  end

  // Select the byte of the run that is on offer.
  always_comb begin
    out_data = run.head;
    unique case (phase)
      PH_DATA: out_data = run.head;
      PH_HI: begin
        out_data.out_byte    = run.code[15:8];
        out_data.byte_kind   = KIND_CODE_HI;
        out_data.group_done  = 1'b0;
        out_data.code_error  = 1'b0;
        out_data.last_of_run = 1'b0;
      end
      PH_LO: begin
        out_data.out_byte    = run.code[7:0];
        out_data.byte_kind   = KIND_CODE_LO;
        out_data.group_done  = 1'b1;
        out_data.code_error  = 1'b0;
        out_data.last_of_run = 1'b1;
      end
      default: out_data = run.head;
    endcase
  end

  // Hold one run and step through its bytes as they are taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      phase <= PH_DATA;
    end else if (load) begin
      valid <= 1'b1;
      phase <= PH_DATA;
      run   <= run_in;
    end else if (valid && out_ready) begin
      if (is_last) begin
        valid <= 1'b0;
      end else begin
        unique case (phase)
          PH_DATA: phase <= PH_HI;
          PH_HI:   phase <= PH_LO;
          default: phase <= PH_DATA;
        endcase
      end
    end
  end

endmodule

// File: design/crc15_pec_framer.sv
// A byte accepted at a clock edge is offered on the output from the next cycle.
// Throughput: one byte per cycle while out_ready is high; a byte that closes
// a group in generate mode holds the input while its data byte and two code
// bytes leave, as the single output register stage holds one run at a time.
// Reset (synchronous, active high) loads the seed, clears the group count and
// selects generate mode with groups of six bytes.
module crc15_pec_framer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  crcpec_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output crcpec_pkg::out_item_t out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [3:0]            cfg_data
);
  import crcpec_pkg::*;
  `include "crc15_pec_framer_assert.svh"

  logic       check_mode;
  logic [3:0] group_bytes;
  logic       accept;
  run_t       run;

  assign accept = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      check_mode  <= 1'b0;
      group_bytes <= 4'd6;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHECK_MODE:  check_mode  <= cfg_data[0];
        CFG_GROUP_BYTES: group_bytes <= cfg_data;
        default:         check_mode  <= check_mode;
      endcase
    end
  end

  crcpec_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (in_data),
    .check_mode  (check_mode),
    .group_bytes (group_bytes),
    .run         (run)
  );

  crcpec_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .run_in    (run),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A mismatch is only ever reported on the byte that closes a group.
  `PEC_ASSERT_NOW(a_err_on_close, out_valid && out_data.code_error, out_data.group_done)
  // An empty output stage always takes the next byte.
  `PEC_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)
  // No byte enters while a run still has code bytes to send.
  `PEC_ASSERT_NOW(a_hold_mid_run, out_valid && !out_data.last_of_run, !in_ready)
  // The high code byte is always followed by the low one.
  `PEC_ASSERT_NEXT(a_hi_then_lo,
    out_valid && out_ready && out_data.byte_kind == KIND_CODE_HI && !out_data.last_of_run,
    out_valid && out_data.byte_kind == KIND_CODE_LO)

endmodule

// File: test/pec_framer_monitor.sv
// Watches both channels and the register port of the framer, predicts every output
// transaction from the accepted input transactions and compares them field by field.
module pec_framer_monitor
  import crcpec_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [3:0] cfg_data,
  output int        outstanding,
  output int        mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Byte-wise remainder table and the predicted state of the block.
  logic [15:0] pec_lut [256];
  logic [14:0] run_crc;
  logic [3:0]  run_count;
  logic [7:0]  held_high;
  logic        check_on;
  logic [3:0]  grp_len;
  out_item_t   awaited_bytes [$];
  out_item_t   want;
  int          faults = 0;

  // Eight shifts of the index through the polynomial, bit 14 being the tap.
  function automatic logic [15:0] lut_entry(input logic [7:0] idx);
    logic [15:0] acc;
    acc = {1'b0, idx, 7'b0};
    repeat (8) acc = acc[14] ? ({acc[14:0], 1'b0} ^ PEC_POLY) : {acc[14:0], 1'b0};
    return acc;
  endfunction

  initial begin
    for (int i = 0; i < 256; i++) begin
      pec_lut[i] = lut_entry(8'(i));
    end
  end

  task automatic restart_group();
    run_crc   = PEC_SEED;
    run_count = 4'd0;
  endtask

  task automatic feed_byte(input logic [7:0] b);
    logic [7:0] idx;
    idx     = run_crc[14:7] ^ b;
    run_crc = {run_crc[6:0], 8'h00} ^ pec_lut[idx][14:0];
  endtask

  task automatic queue_result(input logic [7:0] b, input logic [1:0] kind,
                              input logic done, input logic err, input logic last);
    out_item_t r;
    r.out_byte    = b;
    r.byte_kind   = kind;
    r.group_done  = done;
    r.code_error  = err;
    r.last_of_run = last;
    awaited_bytes.push_back(r);
  endtask

  // Works out the output transactions that one accepted byte causes.
  task automatic predict_byte(input in_item_t item);
    logic [3:0]  limit;
    logic [15:0] code;
    // Out-of-range group lengths are clamped into 1 to MAX_GROUP.
    if (grp_len == 4'd0) begin
      limit = 4'd1;
    end else if (grp_len > MAX_GROUP) begin
      limit = MAX_GROUP;
    end else begin
      limit = grp_len;
    end
    if (item.frame_start) restart_group();

    if (!check_on) begin
      // Generate mode: a full group (or an overfull one after a length change)
      // releases the data byte followed by the two code bytes.
      feed_byte(item.data_byte);
      run_count = run_count + 4'd1;
      if (run_count >= limit) begin
        code = {run_crc, 1'b0};
        queue_result(item.data_byte, KIND_DATA, 1'b0, 1'b0, 1'b0);
        queue_result(code[15:8], KIND_CODE_HI, 1'b0, 1'b0, 1'b0);
        queue_result(code[7:0], KIND_CODE_LO, 1'b1, 1'b0, 1'b1);
        restart_group();
      end else begin
        queue_result(item.data_byte, KIND_DATA, 1'b0, 1'b0, 1'b1);
      end
    end else if (run_count < limit) begin
      feed_byte(item.data_byte);
      run_count = run_count + 4'd1;
      queue_result(item.data_byte, KIND_DATA, 1'b0, 1'b0, 1'b1);
    end else if (run_count == limit) begin
      held_high = item.data_byte;
      run_count = run_count + 4'd1;
      queue_result(item.data_byte, KIND_CODE_HI, 1'b0, 1'b0, 1'b1);
    end else begin
      // Low code byte, also taken when the count has run past the group.
      code = {run_crc, 1'b0};
      queue_result(item.data_byte, KIND_CODE_LO, 1'b1,
                   {held_high, item.data_byte} != code, 1'b1);
      restart_group();
    end
  endtask

  // Register writes, input transactions and output transactions, in that order.
  always @(posedge clk) begin
    if (rst) begin
      restart_group();
      held_high = 8'h00;
      check_on  = 1'b0;
      grp_len   = 4'd6;
      awaited_bytes.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_CHECK_MODE) begin
          check_on = cfg_data[0];
        end else begin
          grp_len = cfg_data;
        end
      end
      if (in_valid && in_ready) predict_byte(in_data);
      if (out_valid && out_ready) begin
        if (awaited_bytes.size() == 0) begin
          $error("output transaction %0h arrived with nothing awaited", out_data);
          faults++;
        end else begin
          want = awaited_bytes.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_data.out_byte);
            faults++;
          end
          if (out_data.byte_kind !== want.byte_kind) begin
            $error("byte_kind: expected %0d, got %0d", want.byte_kind, out_data.byte_kind);
            faults++;
          end
          if (out_data.group_done !== want.group_done) begin
            $error("group_done: expected %0b, got %0b", want.group_done,
                   out_data.group_done);
            faults++;
          end
          if (out_data.code_error !== want.code_error) begin
            $error("code_error: expected %0b, got %0b", want.code_error,
                   out_data.code_error);
            faults++;
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                   out_data.last_of_run);
            faults++;
          end
        end
      end
    end
    outstanding    <= awaited_bytes.size();
    mismatch_count <= faults;
  end

endmodule

// File: test/tb_crc15_pec_framer.sv
// Drives the framer with directed and random byte streams in both modes and
// under several group lengths, and gives the verdict from the monitor's count.
module tb_crc15_pec_framer;
  import crcpec_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] byte_q_t [$];

  localparam logic MODE_GEN   = 1'b0;
  localparam logic MODE_CHECK = 1'b1;
  localparam int   RANDOM_TARGET = 440;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic       cfg_index = CFG_CHECK_MODE;
  logic [3:0] cfg_data = 4'd0;

  int outstanding;
  int mismatch_count;
  int items_sent = 0;
  int squeeze_req = 0;
  int squeeze_done = 0;
  bit steady = 1'b0;

  crc15_pec_framer DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pec_framer_monitor monitor (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .outstanding    (outstanding),
    .mismatch_count (mismatch_count)
  );

  always #1 clk = ~clk;

  // Bit-serial code over a group, used only to build well-formed check frames.
  function automatic logic [15:0] pec_serial(input byte_q_t bytes);
    logic [14:0] r;
    logic        fb;
    r = PEC_SEED;
    foreach (bytes[i]) begin
      for (int k = 7; k >= 0; k--) begin
        fb = bytes[i][k] ^ r[14];
        r  = {r[13:0], 1'b0};
        if (fb) r = r ^ PEC_POLY[14:0];
      end
    end
    return {r, 1'b0};
  endfunction

  function automatic byte_q_t random_bytes(input int len);
    byte_q_t q;
    repeat (len) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  // Offers one byte and returns at the edge where the transaction completes.
  task automatic offer(input logic [7:0] b, input logic fs);
    int       gap;
    in_item_t item;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.data_byte   = b;
    item.frame_start = fs;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // A group opened by frame_start, optionally followed by its code bytes.
  task automatic offer_group(input logic with_code, input byte_q_t grp, input bit fault);
    logic [15:0] pec;
    foreach (grp[k]) offer(grp[k], k == 0);
    if (with_code) begin
      pec = pec_serial(grp);
      if (fault) pec = pec ^ (16'h0001 << $urandom_range(0, 15));
      offer(pec[15:8], 1'b0);
      offer(pec[7:0], 1'b0);
    end
  endtask

  // Waits until every awaited output transaction has arrived, then a short pause.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers; the spare bits of the mode write carry noise.
  task automatic set_config(input logic chk, input logic [3:0] glen);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CHECK_MODE;
    cfg_data  <= {3'($urandom_range(0, 7)), chk};
    @(posedge clk);
    cfg_index <= CFG_GROUP_BYTES;
    cfg_data  <= glen;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed groups with random content, some bad codes, stray
  // bytes and groups cut short.
  task automatic run_phase(input logic chk, input logic [3:0] glen, input int n);
    int target;
    int eff;
    int pick;
    set_config(chk, glen);
    if (glen == 4'd0) begin
      eff = 1;
    end else if (glen > MAX_GROUP) begin
      eff = MAX_GROUP;
    end else begin
      eff = glen;
    end
    target = items_sent + n;
    while (items_sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        offer_group(chk, random_bytes(eff), $urandom_range(0, 3) == 0);
      end else if (pick < 9) begin
        offer(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else begin
        offer_group(1'b0, random_bytes($urandom_range(1, eff)), 1'b0);
      end
    end
    drain();
  endtask

  // Output side: random stalls, calm stretches and the occasional long hold-off.
  initial begin : result_sink
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      if (squeeze_req != squeeze_done) begin
        squeeze_done++;
        out_ready <= 1'b0;
        repeat (48) @(posedge clk);
      end else if (!steady) begin
        stall = $urandom_range(0, 4);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int         phase_no;
    logic       chk;
    logic [3:0] glen;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: generate mode, groups of six, byte extremes.
    offer(8'h00, 1'b1);
    offer(8'hFF, 1'b0);
    offer(8'h80, 1'b0);
    offer(8'h01, 1'b0);
    offer(8'h7F, 1'b0);
    offer(8'hAA, 1'b0);
    drain();

    // Leave a group part-way, then shorten it so the next byte overfills it.
    set_config(MODE_GEN, 4'd8);
    offer(8'h5A, 1'b1);
    offer(8'hC3, 1'b0);
    offer(8'h3C, 1'b0);
    drain();
    set_config(MODE_GEN, 4'd2);
    offer(8'h0F, 1'b0);
    drain();

    // A zero length acts as one.
    set_config(MODE_GEN, 4'd0);
    offer(8'hFF, 1'b0);
    offer(8'h00, 1'b1);
    drain();

    // Check mode: a matching code and a corrupted one.
    set_config(MODE_CHECK, 4'd2);
    offer_group(1'b1, '{8'h11, 8'h22}, 1'b0);
    offer_group(1'b1, '{8'h33, 8'h44}, 1'b1);
    drain();

    // Check mode with the count past the group and its high byte: next byte
    // is taken as the low code byte.
    set_config(MODE_CHECK, 4'd4);
    offer_group(1'b0, '{8'hF0, 8'h0F, 8'hA5}, 1'b0);
    drain();
    set_config(MODE_CHECK, 4'd1);
    offer(8'h5A, 1'b0);
    drain();

    // Random phases, the first eight sweeping the length extremes in both modes.
    phase_no = 0;
    while (items_sent < RANDOM_TARGET) begin
      if (phase_no < 8) begin
        chk = phase_no[0];
        case (phase_no >> 1)
          0:       glen = 4'd1;
          1:       glen = 4'd8;
          2:       glen = 4'd0;
          default: glen = 4'd15;
        endcase
      end else begin
        chk = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 5) == 0) begin
          glen = 4'($urandom_range(8, 15));
          if (glen == 4'd8) glen = 4'd0;
        end else begin
          glen = 4'($urandom_range(1, 8));
        end
      end
      steady = (phase_no == 3) || ($urandom_range(0, 3) == 0);
      if (phase_no == 1 || phase_no == 6) squeeze_req++;
      run_phase(chk, glen, $urandom_range(25, 45));
      phase_no++;
    end

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: crc15_pec_framer.f
+incdir+design
design/crcpec_pkg.sv
design/crcpec_core.sv
design/crcpec_out.sv
design/crc15_pec_framer.sv
test/pec_framer_monitor.sv
test/tb_crc15_pec_framer.sv
